/* rtl/itpc_pkg.sv */
package itpc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;
   localparam int ENTRY_WIDTH = 7;
   localparam int CODE_WIDTH = 5;
   localparam int TAG_WIDTH = 16;
   localparam int NUM_OPS = 6;
   localparam int NUM_FUNCS = 19;

   typedef enum logic [2:0] {
      TK_NUMBER    = 3'd0,
      TK_FUNCTION  = 3'd1,
      TK_COMMA     = 3'd2,
      TK_FACTORIAL = 3'd3,
      TK_OPERATOR  = 3'd4,
      TK_LPAREN    = 3'd5,
      TK_RPAREN    = 3'd6,
      TK_END       = 3'd7
   } token_kind_type;

   typedef enum logic [1:0] {
      ENT_OP    = 2'd0,
      ENT_FUNC  = 2'd1,
      ENT_PAREN = 2'd2
   } entry_kind_type;

   typedef enum logic [1:0] {
      RK_NUM  = 2'd0,
      RK_OP   = 2'd1,
      RK_FUNC = 2'd2,
      RK_FACT = 2'd3
   } out_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_PAREN    = 2'd1,
      ERR_OVERFLOW = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      EMIT_NUMBER = 2'd0,
      EMIT_FACT   = 2'd1,
      EMIT_TOP    = 2'd2,
      EMIT_ERROR  = 2'd3
   } emit_sel_type;

   typedef struct packed {
      out_kind_type            kind;
      logic [CODE_WIDTH-1:0]   code;
      logic [TAG_WIDTH-1:0]    tag;
      error_type               err;
   } result_type;

   typedef struct packed {
      logic         load_token;
      logic         emit;
      emit_sel_type emit_sel;
      logic         flush;
      logic         read_top;
      logic         pop;
      logic         push;
      logic         set_err_paren;
      logic         set_err_over;
      logic         clear_err;
   } cmd_type;

   typedef struct packed {
      token_kind_type kind;
      logic           code_ok;
      logic           count_zero;
      logic           count_one;
      logic           full;
      entry_kind_type top_kind;
      logic           top_pops;
      logic           emit_ok;
      logic           flush_ok;
      logic           pend_valid;
      logic           err_set;
   } status_type;

   function automatic logic [2:0] op_prec(input logic [CODE_WIDTH-1:0] code);
      logic [2:0] p;
      unique case (code)
         5'd0:                   p = 3'd4;
         5'd1, 5'd2, 5'd3:       p = 3'd3;
         5'd4, 5'd5:             p = 3'd2;
         default:                p = 3'd0;
      endcase
      return p;
   endfunction

   function automatic logic op_right(input logic [CODE_WIDTH-1:0] code);
      return code == 5'd0;
   endfunction

endpackage

/* rtl/infix_to_postfix_converter.sv */
// A token is taken in IDLE and decoded in DECODE. A number or factorial result
// goes to a pending register and moves to the output register when the next
// result is emitted or at the flush in FINISH. Each stack entry examined takes
// a RAM read (FETCH), then a decision (CHECK); a push has its own PUSH step.
// One token is in flight at a time; a held result stalls the emit steps.
// Reset (synchronous, active high) empties the stack and clears the pending and output valid flags.
module infix_to_postfix_converter
   import itpc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // op_code[4:0], token_tag[20:5], zero pad
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_code[4:0], out_tag[20:5], error[22:21], pad
   output logic [1:0]  rsp_tuser,   // out_kind[1:0]
   output logic        rsp_tlast
);

   cmd_type    cmd;
   status_type sts;

   itpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   itpc_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

/* rtl/itpc_ram.sv */
module itpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/itpc_ctrl.sv */
module itpc_ctrl
   import itpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_PUSH   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_token = 1'b1;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.kind)
               TK_NUMBER, TK_FACTORIAL: begin
                  if (sts.emit_ok) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = (sts.kind == TK_NUMBER) ? EMIT_NUMBER : EMIT_FACT;
                     state_in     = ST_FINISH;
                  end
               end
               TK_COMMA:    state_in = ST_FINISH;
               TK_FUNCTION: state_in = sts.code_ok ? ST_PUSH : ST_FINISH;
               TK_OPERATOR: begin
                  if (!sts.code_ok) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = sts.count_zero ? ST_PUSH : ST_FETCH;
                  end
               end
               TK_LPAREN:   state_in = sts.count_zero ? ST_PUSH : ST_FETCH;
               TK_RPAREN: begin
                  if (sts.count_zero) begin
                     cmd.set_err_paren = 1'b1;
                     state_in          = ST_FINISH;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
               TK_END:      state_in = sts.count_zero ? ST_FINISH : ST_FETCH;
               default:     state_in = ST_FINISH;
            endcase
         end
         ST_FETCH: begin
            cmd.read_top = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            unique case (sts.kind)
               TK_OPERATOR: begin
                  priority if (sts.top_pops) begin
                     if (sts.emit_ok) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_TOP;
                        cmd.pop      = 1'b1;
                        state_in     = sts.count_one ? ST_PUSH : ST_FETCH;
                     end
                  end else begin
                     state_in = ST_PUSH;
                  end
               end
               TK_LPAREN: begin
                  state_in = (sts.top_kind == ENT_FUNC) ? ST_FINISH : ST_PUSH;
               end
               TK_RPAREN: begin
                  priority if (sts.top_kind == ENT_PAREN) begin
                     cmd.pop  = 1'b1;
                     state_in = ST_FINISH;
                  end else if (sts.emit_ok) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = EMIT_TOP;
                     cmd.pop      = 1'b1;
                     priority if (sts.top_kind == ENT_FUNC) begin
                        state_in = ST_FINISH;
                     end else if (sts.count_one) begin
                        cmd.set_err_paren = 1'b1;
                        state_in          = ST_FINISH;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
               end
               TK_END: begin
                  priority if (sts.top_kind == ENT_PAREN) begin
                     cmd.pop           = 1'b1;
                     cmd.set_err_paren = 1'b1;
                     state_in          = sts.count_one ? ST_FINISH : ST_FETCH;
                  end else if (sts.emit_ok) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = EMIT_TOP;
                     cmd.pop      = 1'b1;
                     state_in     = sts.count_one ? ST_FINISH : ST_FETCH;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_PUSH: begin
            if (sts.full) begin
               cmd.set_err_over = 1'b1;
            end else begin
               cmd.push = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            priority if (sts.err_set) begin
               if (sts.emit_ok) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_ERROR;
                  cmd.clear_err = 1'b1;
               end
            end else if (sts.pend_valid) begin
               if (sts.flush_ok) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/itpc_datapath.sv */
module itpc_datapath
   import itpc_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [23:0] req_tdata,
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  cmd_type     cmd,
   output status_type  sts
);

   localparam int CountWidth = $clog2(STACK_DEPTH + 1);
   localparam int AddrWidth  = $clog2(STACK_DEPTH);

   token_kind_type          kind_ff;
   logic [CODE_WIDTH-1:0]   code_ff;
   logic [TAG_WIDTH-1:0]    tag_ff;
   logic [CountWidth-1:0]   count_ff, count_in, count_dec;
   error_type               err_ff, err_in;
   result_type              pend_ff, pend_in, rsp_ff, rsp_in, new_res;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [ENTRY_WIDTH-1:0]  top_entry, push_entry;
   entry_kind_type          top_kind, push_kind;
   logic [CODE_WIDTH-1:0]   top_code;
   logic                    rsp_free;

   assign count_dec = count_ff - 1'b1;

   itpc_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data (push_entry),
      .rd_en   (cmd.read_top),
      .rd_addr (count_dec[AddrWidth-1:0]),
      .rd_data (top_entry)
   );

   assign top_kind = entry_kind_type'(top_entry[6:5]);
   assign top_code = top_entry[4:0];

   always_comb begin
      unique case (kind_ff)
         TK_FUNCTION: push_kind = ENT_FUNC;
         TK_LPAREN:   push_kind = ENT_PAREN;
         default:     push_kind = ENT_OP;
      endcase
      push_entry = {push_kind, (kind_ff == TK_LPAREN) ? '0 : code_ff};
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      sts            = '0;
      sts.kind       = kind_ff;
      sts.code_ok    = (kind_ff == TK_FUNCTION) ? (code_ff < CODE_WIDTH'(NUM_FUNCS))
                                                : (code_ff < CODE_WIDTH'(NUM_OPS));
      sts.count_zero = (count_ff == '0);
      sts.count_one  = (count_ff == CountWidth'(1));
      sts.full       = (count_ff == CountWidth'(STACK_DEPTH));
      sts.top_kind   = top_kind;
      sts.top_pops   = (top_kind == ENT_OP) && (top_code < CODE_WIDTH'(NUM_OPS)) &&
                       (op_right(code_ff) ? (op_prec(code_ff) <  op_prec(top_code))
                                          : (op_prec(code_ff) <= op_prec(top_code)));
      sts.emit_ok    = !pend_valid_ff || rsp_free;
      sts.flush_ok   = rsp_free;
      sts.pend_valid = pend_valid_ff;
      sts.err_set    = (err_ff != ERR_NONE);
   end

   always_comb begin
      new_res = '{kind: RK_NUM, code: '0, tag: '0, err: ERR_NONE};
      unique case (cmd.emit_sel)
         EMIT_NUMBER: new_res.tag  = tag_ff;
         EMIT_FACT:   new_res.kind = RK_FACT;
         EMIT_TOP: begin
            new_res.kind = (top_kind == ENT_FUNC) ? RK_FUNC : RK_OP;
            new_res.code = top_code;
         end
         EMIT_ERROR:  new_res.err  = err_ff;
         default:     new_res.err  = ERR_NONE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      err_in        = err_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (cmd.pop) begin
         count_in = count_dec;
      end else if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end

      priority if (cmd.clear_err) begin
         err_in = ERR_NONE;
      end else if (cmd.set_err_paren) begin
         err_in = ERR_PAREN;
      end else if (cmd.set_err_over) begin
         err_in = ERR_OVERFLOW;
      end

      if (cmd.emit) begin
         if (pend_valid_ff) begin
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         pend_in       = new_res;
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         rsp_in        = pend_ff;
         rsp_last_in   = 1'b1;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         err_ff        <= ERR_NONE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         err_ff        <= err_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_token) begin
         kind_ff <= token_kind_type'(req_tuser);
         code_ff <= req_tdata[4:0];
         tag_ff  <= req_tdata[20:5];
      end
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.err, rsp_ff.tag, rsp_ff.code};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

endmodule
